// ----- rtl/fqks_pkg.sv -----
// ----------------------------------------------------------------------------
// fqks_pkg
// Shared types, sizes and codes for the key queue with search.
// ----------------------------------------------------------------------------
package fqks_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 64;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SERVED_W  = 16;

    localparam logic [1:0] KIND_ENQ    = 2'd0;
    localparam logic [1:0] KIND_DEQ    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [4:0]  position;
        logic [4:0]  occupancy;
        logic [15:0] served_total;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    // Ring buffer slot advance, wrapping at DEPTH.
    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
        logic [ADDR_W-1:0] r;
        if (i == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/fqks_key_store.sv -----
// ----------------------------------------------------------------------------
// fqks_key_store
// Key memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fqks_key_store (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [fqks_pkg::ADDR_W-1:0]    i_wr_addr,
    input  logic [fqks_pkg::KEY_WIDTH-1:0] i_wr_data,
    input  logic [fqks_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [fqks_pkg::KEY_WIDTH-1:0] o_rd_data
);
    import fqks_pkg::*;

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- rtl/fifo_queue_with_key_search.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_key_search
// Bounded FIFO of keys in a ring buffer with enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// Enqueue, dequeue, an undefined kind and a search of an empty queue answer in
// the cycle after acceptance, and such items can be accepted every cycle. A search
// reads one stored key per cycle from the head and answers on the first match or
// after the last stored key, and busy holds the next item off until it answers.
// Synchronous reset empties the queue and clears the served count.
module fifo_queue_with_key_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  fqks_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output fqks_pkg::t_out_item o_result
);
    import fqks_pkg::*;

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_head, n_head;
    logic [ADDR_W-1:0]      r_tail, n_tail;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SERVED_W-1:0]    r_served, n_served;
    logic                   r_cmp_valid, n_cmp_valid;
    logic                   r_done, n_done;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [ADDR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_cmp_pos, n_cmp_pos;
    t_out_item              r_result, n_result;

    logic                   accept;
    logic                   wr_en;
    logic [KEY_WIDTH-1:0]   rd_data;
    logic                   match;
    logic                   last;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_item.kind == KIND_ENQ) && (r_count != CNT_W'(DEPTH));

    fqks_key_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_item.key[KEY_WIDTH-1:0]),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign match = r_cmp_valid && (rd_data == r_key);
    assign last  = (r_cmp_pos == CNT_W'(r_count - 1'b1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_served    = r_served;
        n_cmp_valid = r_cmp_valid;
        n_done      = 1'b0;
        n_key       = r_key;
        n_rd_ptr    = r_rd_ptr;
        n_cmp_pos   = r_cmp_pos;
        n_result    = r_result;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done                = 1'b1;
                    n_result.status       = ST_OK;
                    n_result.found        = 1'b0;
                    n_result.position     = '0;
                    case (i_item.kind)
                        KIND_ENQ: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                n_tail  = next_slot(r_tail);
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_count == '0) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_head  = next_slot(r_head);
                                n_count = r_count - 1'b1;
                                if (r_served != '1) begin
                                    n_served = r_served + 1'b1;
                                end
                            end
                        end
                        KIND_SEARCH: begin
                            if (r_count == '0) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                // Walk starts at the head; the result waits for the walk.
                                n_done      = 1'b0;
                                n_state     = S_SEARCH;
                                n_key       = i_item.key[KEY_WIDTH-1:0];
                                n_rd_ptr    = r_head;
                                n_cmp_valid = 1'b0;
                                n_cmp_pos   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_result.occupancy    = 5'(n_count);
                    n_result.served_total = n_served;
                end
            end
            S_SEARCH: begin
                // Reads run one slot ahead of the compare.
                n_rd_ptr    = next_slot(r_rd_ptr);
                n_cmp_valid = 1'b1;
                if (r_cmp_valid) begin
                    if (match) begin
                        n_done            = 1'b1;
                        n_state           = S_IDLE;
                        n_result.found    = 1'b1;
                        n_result.position = 5'(CNT_W'(r_cmp_pos + 1'b1));
                    end else if (last) begin
                        n_done            = 1'b1;
                        n_state           = S_IDLE;
                        n_result.found    = 1'b0;
                        n_result.position = '0;
                    end else begin
                        n_cmp_pos = r_cmp_pos + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_served    <= '0;
            r_cmp_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_served    <= n_served;
            r_cmp_valid <= n_cmp_valid;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_rd_ptr  <= n_rd_ptr;
        r_cmp_pos <= n_cmp_pos;
        r_result  <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
